// ===== hdl/dsk_pkg.sv =====
// Shared types and constants for the Debye sinc kernel.
// Fixed-point constants, reciprocals for the constant divides, and the stage sideband.
// No dependencies.
package dsk_pkg;

  localparam logic [30:0] TWO_PI_Q28  = 31'd1686629713;
  localparam logic [30:0] HALF_PI_Q30 = 31'd1686629713;
  localparam logic [30:0] ONE_Q30     = 31'h4000_0000;
  localparam logic [33:0] THR_RESET   = 34'd1049;
  localparam logic [16:0] OUT_ONE     = 17'h10000;

  // floor(2^42 / 2pi_q28) and floor(2^63 / 2pi_q28)
  localparam logic [11:0] RECIP_RED   = 12'((64'd1 << 42) / 64'd1686629713);
  localparam logic [32:0] RECIP_PHASE = 33'((64'd1 << 63) / 64'd1686629713);

  localparam int unsigned NUM_HORNER = 5;
  localparam int unsigned HORNER_DIV [NUM_HORNER] = '{110, 72, 42, 20, 6};
  localparam int unsigned QUO_W = 17;

  typedef struct packed {
    logic        vld;
    logic        use_poly;
    logic        neg;
    logic        ovf;
    logic [16:0] poly;
    logic [33:0] x;
  } dsk_side_t;

endpackage

// ===== hdl/dsk_poly.sv =====
// Small-argument path: 1 - x^2/6 + x^4/120, rounded to 65536 = 1.0, five stages.
// Depends on dsk_pkg.
module dsk_poly (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        vld_i,
  input  logic [33:0] x_i,
  output logic        vld_o,
  output logic [16:0] val_o
);
  import dsk_pkg::*;

  localparam logic [33:0] SAT_LIMIT = 34'h80_0000;
  localparam logic [29:0] R6   = 30'((64'd1 << 32) / 64'd6);
  localparam logic [25:0] R120 = 26'((64'd1 << 32) / 64'd120);

  logic [4:0]  vld_r;
  logic [3:0]  sat_r;
  logic [25:0] x2_1_r, x2_2_r;
  logic [31:0] x4_2_r, x4_3_r;
  logic [23:0] d6e_2_r, d6c_3_r, d6c_4_r;
  logic [25:0] d120e_3_r, d120c_4_r;
  logic [16:0] val_r;

  logic [45:0] sq_nxt;
  logic [51:0] sq2_nxt;
  logic [55:0] p6_nxt;
  logic [57:0] p120_nxt;
  logic [25:0] rem6_nxt;
  logic [31:0] rem120_nxt;
  logic [23:0] d6c_nxt;
  logic [25:0] d120c_nxt;
  logic [27:0] sum_nxt;
  logic [23:0] rnd_nxt;
  logic [16:0] val_nxt;

  always_comb begin
    sq_nxt     = 46'(x_i[22:0]) * 46'(x_i[22:0]);
    sq2_nxt    = 52'(x2_1_r) * 52'(x2_1_r);
    p6_nxt     = 56'(x2_1_r) * 56'(R6);
    p120_nxt   = 58'(x4_2_r) * 58'(R120);
    // reciprocal estimates are at most one low
    rem6_nxt   = x2_2_r - 26'(26'(d6e_2_r) * 26'd6);
    d6c_nxt    = (rem6_nxt >= 26'd6) ? d6e_2_r + 24'd1 : d6e_2_r;
    rem120_nxt = x4_3_r - 32'(32'(d120e_3_r) * 32'd120);
    d120c_nxt  = (rem120_nxt >= 32'd120) ? d120e_3_r + 26'd1 : d120e_3_r;
    sum_nxt    = 28'h10_0000 - 28'(d6c_4_r) + 28'(d120c_4_r) + 28'd8;
    rnd_nxt    = sum_nxt[27:4];
    if (sat_r[3] || rnd_nxt > 24'(OUT_ONE)) begin
      val_nxt = OUT_ONE;
    end else begin
      val_nxt = rnd_nxt[16:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[3:0], vld_i};
    end
  end

  always_ff @(posedge clk) begin
    sat_r     <= {sat_r[2:0], x_i >= SAT_LIMIT};
    x2_1_r    <= sq_nxt[45:20];
    x2_2_r    <= x2_1_r;
    x4_2_r    <= sq2_nxt[51:20];
    d6e_2_r   <= p6_nxt[55:32];
    x4_3_r    <= x4_2_r;
    d6c_3_r   <= d6c_nxt;
    d120e_3_r <= p120_nxt[57:32];
    d6c_4_r   <= d6c_3_r;
    d120c_4_r <= d120c_nxt;
    val_r     <= val_nxt;
  end

  assign vld_o = vld_r[4];
  assign val_o = val_r;

endmodule

// ===== hdl/dsk_horner_cell.sv =====
// One Horner step of the sine series: a = 1 - (t2*a)/DIV, three stages deep.
// Depends on dsk_pkg.
module dsk_horner_cell #(
  parameter int unsigned DIV = 6
) (
  input  logic              clk,
  input  logic              rst_n,
  input  dsk_pkg::dsk_side_t side_i,
  input  logic [30:0]       t_i,
  input  logic [31:0]       t2_i,
  input  logic [30:0]       a_i,
  output dsk_pkg::dsk_side_t side_o,
  output logic [30:0]       t_o,
  output logic [31:0]       t2_o,
  output logic [30:0]       a_o
);
  import dsk_pkg::*;

  localparam logic [31:0] RECIP = 32'((64'd1 << 32) / 64'(DIV));
  localparam logic [31:0] DIVC  = 32'(DIV);

  dsk_side_t   side_a_r, side_b_r, side_c_r;
  logic [30:0] t_a_r, t_b_r, t_c_r;
  logic [31:0] t2_a_r, t2_b_r, t2_c_r;
  logic [31:0] m_a_r, m_b_r, qe_b_r;
  logic [30:0] a_c_r;

  logic [62:0] pa_nxt;
  logic [63:0] pb_nxt;
  logic [31:0] rem_nxt;
  logic [31:0] qc_nxt;

  always_comb begin
    pa_nxt  = 63'(t2_i) * 63'(a_i);
    pb_nxt  = 64'(m_a_r) * 64'(RECIP);
    rem_nxt = m_b_r - 32'(qe_b_r * DIVC);
    qc_nxt  = (rem_nxt >= DIVC) ? qe_b_r + 32'd1 : qe_b_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      side_a_r <= '0;
      side_b_r <= '0;
      side_c_r <= '0;
    end else begin
      side_a_r <= side_i;
      side_b_r <= side_a_r;
      side_c_r <= side_b_r;
    end
  end

  always_ff @(posedge clk) begin
    t_a_r  <= t_i;
    t2_a_r <= t2_i;
    m_a_r  <= pa_nxt[61:30];
    t_b_r  <= t_a_r;
    t2_b_r <= t2_a_r;
    m_b_r  <= m_a_r;
    qe_b_r <= pb_nxt[63:32];
    t_c_r  <= t_b_r;
    t2_c_r <= t2_b_r;
    a_c_r  <= ONE_Q30 - qc_nxt[30:0];
  end

  assign side_o = side_c_r;
  assign t_o    = t_c_r;
  assign t2_o   = t2_c_r;
  assign a_o    = a_c_r;

endmodule

// ===== hdl/dsk_div_cell.sv =====
// One restoring-division step: compares the partial remainder with x << BIT.
// Depends on dsk_pkg.
module dsk_div_cell #(
  parameter int unsigned BIT = 0
) (
  input  logic              clk,
  input  logic              rst_n,
  input  dsk_pkg::dsk_side_t side_i,
  input  logic [37:0]       rem_i,
  input  logic [16:0]       quo_i,
  output dsk_pkg::dsk_side_t side_o,
  output logic [37:0]       rem_o,
  output logic [16:0]       quo_o
);
  import dsk_pkg::*;

  dsk_side_t   side_r;
  logic [37:0] rem_r;
  logic [16:0] quo_r;

  logic [50:0] dsh_nxt;
  logic [50:0] diff_nxt;
  logic        ge_nxt;

  always_comb begin
    dsh_nxt  = 51'(side_i.x) << BIT;
    ge_nxt   = 51'(rem_i) >= dsh_nxt;
    diff_nxt = 51'(rem_i) - dsh_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      side_r <= '0;
    end else begin
      side_r <= side_i;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= ge_nxt ? diff_nxt[37:0] : rem_i;
    quo_r <= {quo_i[15:0], ge_nxt};
  end

  assign side_o = side_r;
  assign rem_o  = rem_r;
  assign quo_o  = quo_r;

endmodule

// ===== hdl/debye_sinc_kernel.sv =====
// Top level of the Debye kernel sin(q*d)/(q*d), fully pipelined.
// Depends on dsk_pkg, dsk_poly, dsk_horner_cell, dsk_div_cell.
//
// Usage:
//   Input: drive in_q_value and in_distance with start; the transaction is taken
//   at a rising edge where start is high and busy is low. busy is high only
//   during reset and the cycle after it, so one transaction per cycle is taken.
//   Output: out_sinc_value is valid for the single cycle out_strobe is high;
//   there is no backpressure, results leave in input order.
//   Throughput: one result per cycle. Depth is set by the angle reduction
//   (10 stages), five Horner cells of three stages, the product stage,
//   the dividend stage, 17 one-bit divider cells and the output register.
//   Config: cfg_small_arg_threshold is written when cfg_valid and cfg_ready
//   are high; write it only with the pipeline empty.
//   Reset: synchronous, active low; clears all valid bits and loads the
//   threshold with its default of 1049.
module debye_sinc_kernel (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [17:0]        in_q_value,
  input  logic [15:0]        in_distance,
  output logic               out_strobe,
  output logic signed [17:0] out_sinc_value,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [33:0]        cfg_small_arg_threshold
);
  import dsk_pkg::*;

  logic        busy_r;
  logic [33:0] thr_r;

  logic        v1_r, v2_r, v3_r, v4_r, v5_r, v6_r;
  logic [33:0] x1_r, x2_r, x3_r, x4_r, x5_r, x6_r;
  logic        sel2_r, sel3_r, sel4_r, sel5_r, sel6_r;
  logic [11:0] qr2_r;
  logic [31:0] rr3_r;
  logic [30:0] r4_r, r5_r;
  logic [31:0] ph5_r, ph6_r, rem6_r, phase7_r;
  dsk_side_t   side7_r, side8_r, side9_r, side10_r, side_s_r, side_n_r;
  logic [30:0] fm8_r, t9_r, t10_r, s_r;
  logic [31:0] t2_10_r;
  logic [37:0] n_r;
  logic        out_strobe_r;
  logic [17:0] out_val_r;

  logic        poly_vld;
  logic [16:0] poly_val;

  logic [33:0] x1_nxt;
  logic [53:0] red_nxt;
  logic [42:0] rr_nxt;
  logic [63:0] php_nxt;
  logic [62:0] phr_nxt;
  logic [61:0] tp_nxt, t2p_nxt, sp_nxt;
  logic [31:0] phase_nxt;
  logic [30:0] fm_nxt;
  logic [37:0] n_nxt;
  logic        ovf_nxt;
  logic [16:0] mag_nxt;
  logic [17:0] val_nxt;
  dsk_side_t   side7_nxt, side8_nxt, side_n_nxt;
  logic        take;

  dsk_side_t   h_side [NUM_HORNER+1];
  logic [30:0] h_t    [NUM_HORNER+1];
  logic [31:0] h_t2   [NUM_HORNER+1];
  logic [30:0] h_a    [NUM_HORNER+1];
  dsk_side_t   d_side [QUO_W+1];
  logic [37:0] d_rem  [QUO_W+1];
  logic [16:0] d_quo  [QUO_W+1];

  assign take      = start && !busy_r;
  assign busy      = busy_r;
  assign cfg_ready = !busy_r;

  always_comb begin
    x1_nxt  = 34'(in_q_value) * 34'(in_distance);
    red_nxt = 54'({x1_r, 8'b0}) * 54'(RECIP_RED);
    rr_nxt  = 43'({x2_r, 8'b0}) - 43'(qr2_r) * 43'(TWO_PI_Q28);
    php_nxt = 64'(r4_r) * 64'(RECIP_PHASE);
    phr_nxt = 63'({r5_r, 32'b0}) - 63'(ph5_r) * 63'(TWO_PI_Q28);
    phase_nxt = (rem6_r >= 32'(TWO_PI_Q28)) ? ph6_r + 32'd1 : ph6_r;
    // quadrants one and three run the angle backward
    fm_nxt  = phase7_r[30] ? ONE_Q30 - {1'b0, phase7_r[29:0]} : {1'b0, phase7_r[29:0]};
    tp_nxt  = 62'(fm8_r) * 62'(HALF_PI_Q30);
    t2p_nxt = 62'(t9_r) * 62'(t9_r);
    sp_nxt  = 62'(h_t[NUM_HORNER]) * 62'(h_a[NUM_HORNER]);
    n_nxt   = 38'({s_r, 6'b0}) + 38'(side_s_r.x[33:1]);
    ovf_nxt = 51'(n_nxt) >= {side_s_r.x, 17'b0};
    if (d_side[QUO_W].ovf || d_quo[QUO_W] > OUT_ONE) begin
      mag_nxt = OUT_ONE;
    end else begin
      mag_nxt = d_quo[QUO_W];
    end
    if (d_side[QUO_W].use_poly) begin
      val_nxt = {1'b0, d_side[QUO_W].poly};
    end else if (d_side[QUO_W].neg) begin
      val_nxt = -{1'b0, mag_nxt};
    end else begin
      val_nxt = {1'b0, mag_nxt};
    end
    side7_nxt.vld      = v6_r;
    side7_nxt.use_poly = sel6_r;
    side7_nxt.neg      = 1'b0;
    side7_nxt.ovf      = 1'b0;
    side7_nxt.poly     = poly_val;
    side7_nxt.x        = x6_r;
    side8_nxt          = side7_r;
    side8_nxt.neg      = phase7_r[31];
    side_n_nxt         = side_s_r;
    side_n_nxt.ovf     = ovf_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r       <= 1'b1;
      thr_r        <= THR_RESET;
      v1_r         <= 1'b0;
      v2_r         <= 1'b0;
      v3_r         <= 1'b0;
      v4_r         <= 1'b0;
      v5_r         <= 1'b0;
      v6_r         <= 1'b0;
      out_strobe_r <= 1'b0;
    end else begin
      busy_r       <= 1'b0;
      if (cfg_valid && cfg_ready) begin
        thr_r <= cfg_small_arg_threshold;
      end
      v1_r         <= take;
      v2_r         <= v1_r;
      v3_r         <= v2_r;
      v4_r         <= v3_r;
      v5_r         <= v4_r;
      v6_r         <= v5_r;
      out_strobe_r <= d_side[QUO_W].vld;
    end
  end

  always_ff @(posedge clk) begin
    x1_r   <= x1_nxt;
    x2_r   <= x1_r;
    sel2_r <= (x1_r == '0) || (x1_r < thr_r);
    qr2_r  <= red_nxt[53:42];
    x3_r   <= x2_r;
    sel3_r <= sel2_r;
    rr3_r  <= rr_nxt[31:0];
    x4_r   <= x3_r;
    sel4_r <= sel3_r;
    r4_r   <= (rr3_r >= 32'(TWO_PI_Q28)) ? 31'(rr3_r - 32'(TWO_PI_Q28)) : rr3_r[30:0];
    x5_r   <= x4_r;
    sel5_r <= sel4_r;
    r5_r   <= r4_r;
    ph5_r  <= php_nxt[62:31];
    x6_r   <= x5_r;
    sel6_r <= sel5_r;
    ph6_r  <= ph5_r;
    rem6_r <= phr_nxt[31:0];
    phase7_r <= phase_nxt;
    fm8_r    <= fm_nxt;
    t9_r     <= tp_nxt[60:30];
    t10_r    <= t9_r;
    t2_10_r  <= t2p_nxt[61:30];
    s_r      <= sp_nxt[60:30];
    n_r      <= n_nxt;
    out_val_r <= val_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      side7_r  <= '0;
      side8_r  <= '0;
      side9_r  <= '0;
      side10_r <= '0;
      side_s_r <= '0;
      side_n_r <= '0;
    end else begin
      side7_r  <= side7_nxt;
      side8_r  <= side8_nxt;
      side9_r  <= side8_r;
      side10_r <= side9_r;
      side_s_r <= h_side[NUM_HORNER];
      side_n_r <= side_n_nxt;
    end
  end

  dsk_poly u_poly (
    .clk   (clk),
    .rst_n (rst_n),
    .vld_i (v1_r),
    .x_i   (x1_r),
    .vld_o (poly_vld),
    .val_o (poly_val)
  );

  assign h_side[0] = side10_r;
  assign h_t[0]    = t10_r;
  assign h_t2[0]   = t2_10_r;
  assign h_a[0]    = ONE_Q30;

  for (genvar i = 0; i < NUM_HORNER; i++) begin : g_horner
    dsk_horner_cell #(.DIV(HORNER_DIV[i])) u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .side_i (h_side[i]),
      .t_i    (h_t[i]),
      .t2_i   (h_t2[i]),
      .a_i    (h_a[i]),
      .side_o (h_side[i+1]),
      .t_o    (h_t[i+1]),
      .t2_o   (h_t2[i+1]),
      .a_o    (h_a[i+1])
    );
  end

  assign d_side[0] = side_n_r;
  assign d_rem[0]  = n_r;
  assign d_quo[0]  = '0;

  // quotient bits MSB first
  for (genvar j = 0; j < QUO_W; j++) begin : g_div
    dsk_div_cell #(.BIT(QUO_W - 1 - j)) u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .side_i (d_side[j]),
      .rem_i  (d_rem[j]),
      .quo_i  (d_quo[j]),
      .side_o (d_side[j+1]),
      .rem_o  (d_rem[j+1]),
      .quo_o  (d_quo[j+1])
    );
  end

  assign out_strobe     = out_strobe_r;
  assign out_sinc_value = $signed(out_val_r);

  a_poly_align: assert property (@(posedge clk) disable iff (!rst_n)
    poly_vld == v6_r)
    else $error("polynomial result out of step with sine pipeline");

  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##45 out_strobe)
    else $error("accepted transaction produced no result");

  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(start && !busy, 45))
    else $error("result without an accepted transaction");

  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> (out_sinc_value >= -18'sd65536 && out_sinc_value <= 18'sd65536))
    else $error("result outside unit range");

endmodule
